@@ hdl/lpcm_pkg.sv @@
`default_nettype none
package lpcm_pkg;

  typedef enum logic [1:0] {
    OP_PIXEL   = 2'd0,
    OP_LINE    = 2'd1,
    OP_PALWR   = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_MATH_CTRL   = 3'd0,
    REG_LAYER_MATH  = 3'd1,
    REG_FIXED_COLOR = 3'd2,
    REG_BG_MODE     = 3'd3,
    REG_PSEUDO_HIRES = 3'd4,
    REG_BRIGHTNESS  = 3'd5,
    REG_BLANK       = 3'd6,
    REG_OVERSCAN    = 3'd7
  } reg_idx_t;

  localparam int CFG_DW = 15;
  localparam int CFG_AW = 3;
  localparam logic [2:0] NO_LAYER = 3'd5;
  localparam logic [8:0] BLANK_LINE = 9'd225;
  localparam logic [7:0] SPRITE_MATH_PAL = 8'd192;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  palette_write_addr;
    logic [14:0] palette_write_data;
    logic [8:0]  line_number;
    logic [59:0] main_layers;
    logic [59:0] sub_layers;
    logic [2:0]  main_bg1_group;
    logic [2:0]  sub_bg1_group;
    logic        window_main_enable;
    logic        window_sub_enable;
  } in_word_t;

  typedef struct packed {
    logic [18:0] first_pixel;
    logic [18:0] second_pixel;
  } out_word_t;

  // classified screen: winning layer and palette index (or direct colour)
  typedef struct packed {
    logic [2:0]  win;
    logic [7:0]  pal;
    logic        direct;
    logic [14:0] dcolor;
  } scr_t;

  // word handed from front to back
  typedef struct packed {
    op_t         op;
    logic [7:0]  waddr;
    logic [14:0] wdata;
    logic        blank;
    logic        emit;
    logic        hires;
    logic        win_main;
    logic        win_sub;
    scr_t        m;
    scr_t        s;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  math_control;
    logic [5:0]  layer_math_enable;
    logic [14:0] fixed_color;
    logic [2:0]  background_mode;
    logic        pseudo_hires;
    logic [3:0]  display_brightness;
    logic        display_blank;
    logic        overscan_on;
  } cfg_t;

  function automatic logic [14:0] direct_color(input logic [7:0] pal, input logic [2:0] grp);
    logic [14:0] r;
    r = '0;
    r[14:13] = pal[7:6];
    r[12]    = grp[2];
    r[9:7]   = pal[5:3];
    r[6]     = grp[1];
    r[4:2]   = pal[2:0];
    r[1]     = grp[0];
    return r;
  endfunction

  function automatic logic [14:0] blend(input logic [14:0] x, input logic [14:0] y,
                                        input logic sub, input logic halve);
    logic [16:0] sum, carry, diff, borrow, r;
    sum = '0; carry = '0; diff = '0; borrow = '0; r = '0;
    if (!sub) begin
      sum = {2'b0, x} + {2'b0, y};
      if (!halve) begin
        carry = (sum - {2'b0, (x ^ y) & 15'h0421}) & 17'h8420;
        r = (sum - carry) | (carry - (carry >> 5));
      end else begin
        r = (sum - {2'b0, (x ^ y) & 15'h0421}) >> 1;
      end
    end else begin
      diff = {2'b0, x} - {2'b0, y} + 17'h8420;
      borrow = (diff - {2'b0, (x ^ y) & 15'h0420}) & 17'h8420;
      r = (diff - borrow) & (borrow - (borrow >> 5));
      if (halve) r = (r & 17'h7bde) >> 1;
    end
    return r[14:0];
  endfunction

endpackage
`default_nettype wire

@@ hdl/lpcm_front.sv @@
`default_nettype none
module lpcm_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  lpcm_pkg::cfg_t       cfg,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  lpcm_pkg::in_word_t   in_data,
  output logic                 q_valid,
  input  wire                  q_stall,
  output lpcm_pkg::cmd_t       q_data
);
  import lpcm_pkg::*;

  // two-entry queue towards the back end
  cmd_t       buf_r [2];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cmd;
  logic       direct_ok;
  logic [9:0] row;

  function automatic scr_t classify(input logic [59:0] layers, input logic [2:0] grp,
                                    input logic dok);
    scr_t       s;
    logic [3:0] best;
    logic [3:0] pri;
    s = '0;
    s.win = NO_LAYER;
    best = '0;
    pri = '0;
    for (int i = 0; i < 5; i++) begin
      pri = layers[12*i+8 +: 4];
      if (pri > best) begin
        best = pri;
        s.win = 3'(i);
        s.pal = layers[12*i +: 8];
        s.direct = (i == 0) && dok;
      end
    end
    s.dcolor = direct_color(s.pal, grp);
    return s;
  endfunction

  always_comb begin
    direct_ok = cfg.math_control[1] && (cfg.background_mode == 3'd3 ||
                cfg.background_mode == 3'd4 || cfg.background_mode == 3'd7);
    row = {1'b0, in_data.line_number} + (cfg.overscan_on ? 10'd0 : 10'd8);
    cmd = '0;
    cmd.op = op_t'(in_data.op);
    cmd.waddr = in_data.palette_write_addr;
    cmd.wdata = in_data.palette_write_data;
    cmd.blank = cfg.display_blank || (!cfg.overscan_on && in_data.line_number >= BLANK_LINE);
    cmd.emit = (row < 10'd240);
    cmd.hires = cfg.pseudo_hires || cfg.background_mode == 3'd5 ||
                cfg.background_mode == 3'd6;
    cmd.win_main = in_data.window_main_enable;
    cmd.win_sub = in_data.window_sub_enable;
    cmd.m = classify(in_data.main_layers, in_data.main_bg1_group, direct_ok);
    cmd.s = classify(in_data.sub_layers, in_data.sub_bg1_group, direct_ok);
    // line zero pixels and spare ops are dropped here
    if (in_data.line_number == 9'd0 && cmd.op == OP_PIXEL) cmd.op = OP_NOP;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall && (cmd.op != OP_NOP);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = buf_r[rp_r];
  assign pop = q_valid && !q_stall;

  always_comb begin
    wp_nxt = wp_r ^ push;
    rp_nxt = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= cmd;
  end

endmodule
`default_nettype wire

@@ hdl/lpcm_back.sv @@
`default_nettype none
module lpcm_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  lpcm_pkg::cfg_t       cfg,
  input  wire                  q_valid,
  output logic                 q_stall,
  input  lpcm_pkg::cmd_t       q_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output lpcm_pkg::out_word_t  out_data
);
  import lpcm_pkg::*;

  logic [14:0] pal_ram [256];

  // stage 1: palette reads registered
  logic        s1_valid_r;
  cmd_t        s1_r;
  logic [14:0] m_rd_r, s_rd_r, bd_rd_r;

  // math state
  logic [14:0] main_color_r, sub_color_r;
  logic        main_en_r, sub_en_r, sub_tr_r, bws_r, halve_r;
  logic [14:0] main_color_nxt, sub_color_nxt;
  logic        main_en_nxt, sub_en_nxt, sub_tr_nxt, bws_nxt, halve_nxt;

  logic        out_valid_r;
  out_word_t   out_r;
  logic        adv, out_free;
  logic [14:0] below, above, mcol, scol;
  logic        se, me, bw, hv;

  // stage 1 moves when it is empty or the output slot is free or draining
  assign out_free = !out_valid_r || !out_stall;
  assign adv = !s1_valid_r || out_free;
  assign q_stall = !adv;

  // backdrop entry shadowed in a register so the RAM sees two reads a cycle
  always_ff @(posedge clk) begin
    if (q_valid && adv && q_data.op == OP_PALWR) begin
      pal_ram[q_data.waddr] <= q_data.wdata;
      if (q_data.waddr == 8'd0) bd_rd_r <= q_data.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= q_data;
      m_rd_r <= pal_ram[q_data.m.pal];
      s_rd_r <= pal_ram[q_data.s.pal];
    end
  end

  always_comb begin
    main_color_nxt = main_color_r;
    sub_color_nxt = sub_color_r;
    main_en_nxt = main_en_r;
    sub_en_nxt = sub_en_r;
    sub_tr_nxt = sub_tr_r;
    bws_nxt = bws_r;
    halve_nxt = halve_r;
    below = '0;
    above = '0;
    mcol = '0;
    scol = '0;
    se = 1'b0;
    me = 1'b0;
    bw = 1'b0;
    hv = 1'b0;
    unique case (s1_r.op)
      OP_LINE: begin
        main_color_nxt = bd_rd_r;
        sub_color_nxt = bd_rd_r;
        main_en_nxt = 1'b0;
        sub_en_nxt = 1'b0;
        sub_tr_nxt = 1'b1;
        bws_nxt = 1'b0;
        halve_nxt = 1'b0;
      end
      OP_PIXEL: begin
        if (!s1_r.blank) begin
          // sub screen uses the state left by the previous pixel
          scol = (s1_r.s.win == NO_LAYER) ? bd_rd_r :
                 (s1_r.s.direct ? s1_r.s.dcolor : s_rd_r);
          sub_color_nxt = scol;
          sub_tr_nxt = (s1_r.s.win == NO_LAYER);
          if (s1_r.hires) begin
            if (!sub_en_r) below = main_en_r ? scol : 15'd0;
            else below = blend(main_en_r ? scol : 15'd0,
                               bws_r ? main_color_r : cfg.fixed_color,
                               cfg.math_control[2], halve_r);
          end
          mcol = (s1_r.m.win == NO_LAYER) ? bd_rd_r :
                 (s1_r.m.direct ? s1_r.m.dcolor : m_rd_r);
          main_color_nxt = mcol;
          se = cfg.layer_math_enable[s1_r.m.win] && s1_r.win_sub &&
               !(s1_r.m.win == 3'd4 && s1_r.m.pal < SPRITE_MATH_PAL);
          me = s1_r.win_main;
          sub_en_nxt = se;
          main_en_nxt = me;
          if (!se) begin
            above = me ? mcol : 15'd0;
          end else begin
            if (cfg.math_control[0] && sub_tr_nxt) begin
              bw = 1'b0;
              hv = 1'b0;
            end else begin
              bw = cfg.math_control[0];
              hv = cfg.math_control[3] && me;
            end
            bws_nxt = bw;
            halve_nxt = hv;
            above = blend(me ? mcol : 15'd0, bw ? scol : cfg.fixed_color,
                          cfg.math_control[2], hv);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      main_color_r <= '0;
      sub_color_r <= '0;
      main_en_r <= 1'b0;
      sub_en_r <= 1'b0;
      sub_tr_r <= 1'b1;
      bws_r <= 1'b0;
      halve_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_r <= q_valid;
        if (s1_valid_r) begin
          main_color_r <= main_color_nxt;
          sub_color_r <= sub_color_nxt;
          main_en_r <= main_en_nxt;
          sub_en_r <= sub_en_nxt;
          sub_tr_r <= sub_tr_nxt;
          bws_r <= bws_nxt;
          halve_r <= halve_nxt;
        end
      end
      if (out_free) out_valid_r <= s1_valid_r && s1_r.op == OP_PIXEL && s1_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_r.first_pixel <= {cfg.display_brightness, s1_r.hires ? below : above};
      out_r.second_pixel <= {cfg.display_brightness, above};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule
`default_nettype wire

@@ hdl/layer_priority_color_math.sv @@
// The result word passes the queue slot, the palette read and math stage and
// the output register before it is offered.
// Throughput: one word per cycle; a waiting result holds the back end and,
// once the two-entry queue is full, the input. Palette writes land as the word
// enters the palette read stage.
// Reset (rst_n low, synchronous): queue and pipeline empty, cfg registers zero,
// math state cleared with sub screen transparent; palette RAM is not cleared.
`default_nettype none
module layer_priority_color_math (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       cfg_we,
  input  wire [lpcm_pkg::CFG_AW-1:0] cfg_index,
  input  wire [lpcm_pkg::CFG_DW-1:0] cfg_data,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  lpcm_pkg::in_word_t        in_data,
  output logic                      out_valid,
  input  wire                       out_stall,
  output lpcm_pkg::out_word_t       out_data
);
  import lpcm_pkg::*;

  cfg_t cfg_r;
  logic q_valid, q_stall;
  cmd_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MATH_CTRL:    cfg_r.math_control <= cfg_data[3:0];
        REG_LAYER_MATH:   cfg_r.layer_math_enable <= cfg_data[5:0];
        REG_FIXED_COLOR:  cfg_r.fixed_color <= cfg_data;
        REG_BG_MODE:      cfg_r.background_mode <= cfg_data[2:0];
        REG_PSEUDO_HIRES: cfg_r.pseudo_hires <= cfg_data[0];
        REG_BRIGHTNESS:   cfg_r.display_brightness <= cfg_data[3:0];
        REG_BLANK:        cfg_r.display_blank <= cfg_data[0];
        REG_OVERSCAN:     cfg_r.overscan_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lpcm_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_valid(q_valid), .q_stall(q_stall), .q_data(q_data)
  );

  lpcm_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_valid), .q_stall(q_stall), .q_data(q_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // a stalled result word must stay put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed under stall");

  // brightness bits of both pixels agree
  a_bright: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.first_pixel[18:15] == out_data.second_pixel[18:15])
    else $error("pixel brightness mismatch");

  // back end only pushes back when a result is waiting
  a_qstall: assert property (@(posedge clk) disable iff (!rst_n)
    q_stall |-> out_valid && out_stall)
    else $error("queue stalled without output stall");

endmodule
`default_nettype wire
